[rtl/psht_pkg.sv]
// psht_pkg: shared types and constants of the polled station health tracker
// request and response payload structs, status byte layout, function and event codes
// no dependencies
package psht_pkg;

   localparam int STATIONS_DEFAULT = 128;
   localparam int ST_W             = 7;

   typedef enum logic [1:0] {
      FUNC_PREPARE = 2'd0,
      FUNC_OUTCOME = 2'd1,
      FUNC_LOAD    = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      EV_NONE       = 2'd0,
      EV_STATION    = 2'd1,
      EV_LINE_FAULT = 2'd2
   } event_kind_type;

   localparam logic [4:0] LEN_OK        = 5'd2;
   localparam logic [4:0] LEN_EVENT     = 5'd4;
   localparam logic [2:0] CNT_MAX       = 3'd7;
   localparam logic [7:0] FAULT_B1      = 8'hC0;
   localparam logic [7:0] FAULT_B2      = 8'hFF;

   typedef struct packed {
      logic       active;
      logic       ack;
      logic [2:0] cnt1;
      logic [2:0] cnt0;
   } entry_type;

   typedef struct packed {
      func_type         func;
      logic [ST_W-1:0]  station;
      logic             line;
      logic [4:0]       reply_len;
      logic [ST_W-1:0]  reply_addr;
      logic [7:0]       reply_b1;
      logic [7:0]       reply_b2;
      logic [7:0]       entry_value;
   } req_type;

   typedef struct packed {
      logic [7:0]       status;
      logic [7:0]       poll_header;
      logic             needs_reset;
      event_kind_type   event_kind;
      logic [7:0]       event_b1;
      logic [7:0]       event_b2;
      logic             fault_line;
      logic             dropped;
   } rsp_type;

endpackage

[rtl/psht_table.sv]
// psht_table: station status memory with registered read, per-entry valid bits
// and write-to-read forwarding for a write and read at the same edge
// depends on psht_pkg
module psht_table #(
   parameter int STATIONS = psht_pkg::STATIONS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [psht_pkg::ST_W-1:0]  rd_addr,
   input  logic                       wr_en,
   input  logic [psht_pkg::ST_W-1:0]  wr_addr,
   input  psht_pkg::entry_type        wr_data,
   output psht_pkg::entry_type        rd_data
);

   localparam int IDX_W = $clog2(STATIONS);

   psht_pkg::entry_type  mem [STATIONS];
   logic [STATIONS-1:0]  valid_ff;
   logic [STATIONS-1:0]  valid_in;

   psht_pkg::entry_type  rd_mem_ff;
   psht_pkg::entry_type  fwd_data_ff;
   logic                 rd_valid_ff;
   logic                 rd_valid_in;
   logic                 fwd_ff;
   logic                 fwd_in;

   logic                 rd_hit;
   logic                 wr_hit;
   logic [IDX_W-1:0]     rd_idx;
   logic [IDX_W-1:0]     wr_idx;
   logic                 do_write;

   assign rd_hit   = {1'b0, rd_addr} < 8'(STATIONS);
   assign wr_hit   = {1'b0, wr_addr} < 8'(STATIONS);
   assign rd_idx   = rd_addr[IDX_W-1:0];
   assign wr_idx   = wr_addr[IDX_W-1:0];
   assign do_write = wr_en && wr_hit;

   always_comb begin
      valid_in = valid_ff;
      if (do_write) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   assign rd_valid_in = rd_en ? (rd_hit && valid_ff[rd_idx]) : rd_valid_ff;
   assign fwd_in      = rd_en ? (do_write && (rd_addr == wr_addr)) : fwd_ff;

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_mem_ff   <= mem[rd_idx];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
         fwd_ff      <= fwd_in;
      end
   end

   always_comb begin
      if (fwd_ff) begin
         rd_data = fwd_data_ff;
      end else if (rd_valid_ff) begin
         rd_data = rd_mem_ff;
      end else begin
         rd_data = '0;
      end
   end

endmodule

[rtl/psht_update.sv]
// psht_update: per-request status update, poll header and event classification
// purely combinational, sits between the request register and the response register
// depends on psht_pkg
module psht_update #(
   parameter int STATIONS = psht_pkg::STATIONS_DEFAULT
) (
   input  psht_pkg::req_type    req,
   input  psht_pkg::entry_type  entry,
   input  logic                 independent_lines,
   output psht_pkg::rsp_type    rsp,
   output logic                 wr_en,
   output psht_pkg::entry_type  wr_data
);

   logic                 in_range;
   logic                 good;
   logic                 clr1;
   logic                 clr0;
   psht_pkg::entry_type  upd;
   psht_pkg::entry_type  loaded;

   assign in_range = {1'b0, req.station} < 8'(STATIONS);
   assign good     = (req.reply_addr == req.station) &&
                     ((req.reply_len == psht_pkg::LEN_OK) ||
                      (req.reply_len == psht_pkg::LEN_EVENT));
   assign clr1     = (req.line || independent_lines) && (entry.cnt1 != psht_pkg::CNT_MAX);
   assign clr0     = (!req.line || independent_lines) && (entry.cnt0 != psht_pkg::CNT_MAX);
   assign loaded   = psht_pkg::entry_type'(req.entry_value);

   always_comb begin
      rsp     = '0;
      wr_en   = 1'b0;
      upd     = entry;
      wr_data = entry;
      case (req.func)
         psht_pkg::FUNC_PREPARE: begin
            rsp.status = entry;
            if (entry.active) begin
               rsp.poll_header = {entry.ack, req.station};
            end else begin
               rsp.poll_header = {1'b0, req.station};
               rsp.needs_reset = 1'b1;
            end
         end
         psht_pkg::FUNC_OUTCOME: begin
            if (entry.active) begin
               wr_en = 1'b1;
               if (good) begin
                  upd.ack = ~entry.ack;
                  if (clr1) begin
                     upd.cnt1 = '0;
                  end
                  if (clr0) begin
                     upd.cnt0 = '0;
                  end
                  if (req.reply_len == psht_pkg::LEN_EVENT) begin
                     rsp.event_kind = psht_pkg::EV_STATION;
                     rsp.event_b1   = req.reply_b1;
                     rsp.event_b2   = req.reply_b2;
                  end
               end else begin
                  if (req.line) begin
                     if (entry.cnt1 != psht_pkg::CNT_MAX) begin
                        upd.cnt1 = entry.cnt1 + 3'd1;
                        if (entry.cnt1 == psht_pkg::CNT_MAX - 3'd1) begin
                           rsp.event_kind = psht_pkg::EV_LINE_FAULT;
                           rsp.event_b1   = psht_pkg::FAULT_B1;
                           rsp.event_b2   = psht_pkg::FAULT_B2;
                           rsp.fault_line = 1'b1;
                        end
                     end
                  end else begin
                     if (entry.cnt0 != psht_pkg::CNT_MAX) begin
                        upd.cnt0 = entry.cnt0 + 3'd1;
                        if (entry.cnt0 == psht_pkg::CNT_MAX - 3'd1) begin
                           rsp.event_kind = psht_pkg::EV_LINE_FAULT;
                           rsp.event_b1   = psht_pkg::FAULT_B1;
                           rsp.event_b2   = psht_pkg::FAULT_B2;
                        end
                     end
                  end
                  if ((upd.cnt1 == psht_pkg::CNT_MAX) && (upd.cnt0 == psht_pkg::CNT_MAX)) begin
                     upd         = '0;
                     rsp.dropped = 1'b1;
                  end
               end
            end
            wr_data    = upd;
            rsp.status = upd;
         end
         psht_pkg::FUNC_LOAD: begin
            wr_en      = 1'b1;
            wr_data    = loaded;
            rsp.status = in_range ? req.entry_value : 8'h00;
         end
         default: begin
            rsp.status = entry;
         end
      endcase
   end

endmodule

[rtl/polled_station_health_tracker_unit.sv]
// polled_station_health_tracker_unit: top level of the polled station health tracker
// request register, status table, update logic and response register
// depends on psht_pkg, psht_table, psht_update
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------
//   request  | req_valid / req_stall | req_data (psht_pkg::req_type)
//   response | rsp_valid / rsp_stall | rsp_data (psht_pkg::rsp_type)
//   config   | csr_write             | csr_data (independent_lines)
//
// one request per cycle sustained while the response side is not stalled
// request register, then combinational update, then response register
// synchronous reset clears all entry valid bits at once, no clearing pass
// a held response stalls the request side once the request register is also full
module polled_station_health_tracker_unit #(
   parameter int STATIONS = psht_pkg::STATIONS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  psht_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output psht_pkg::rsp_type  rsp_data,
   input  logic               csr_write,
   input  logic               csr_data
);

   logic                 indep_ff;
   logic                 indep_in;
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   psht_pkg::req_type    s1_req_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   psht_pkg::rsp_type    rsp_data_ff;

   logic                 accept;
   logic                 s1_adv;
   logic                 tbl_wr_en;
   psht_pkg::entry_type  tbl_rd_data;
   psht_pkg::entry_type  upd_wr_data;
   logic                 upd_wr_en;
   psht_pkg::rsp_type    upd_rsp;

   assign s1_adv    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;
   assign tbl_wr_en = s1_valid_ff && s1_adv && upd_wr_en;

   assign indep_in     = csr_write ? csr_data : indep_ff;
   assign s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? s1_valid_ff : 1'b1;

   psht_table #(
      .STATIONS (STATIONS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_data.station),
      .wr_en   (tbl_wr_en),
      .wr_addr (s1_req_ff.station),
      .wr_data (upd_wr_data),
      .rd_data (tbl_rd_data)
   );

   psht_update #(
      .STATIONS (STATIONS)
   ) u_update (
      .req               (s1_req_ff),
      .entry             (tbl_rd_data),
      .independent_lines (indep_ff),
      .rsp               (upd_rsp),
      .wr_en             (upd_wr_en),
      .wr_data           (upd_wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         indep_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         indep_ff     <= indep_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_data;
      end
      if (s1_adv && s1_valid_ff) begin
         rsp_data_ff <= upd_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // stall only with both registers full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled with a free register");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.dropped) |-> (rsp_data.status == 8'h00))
      else $error("dropped entry not cleared");

   a_reset_inactive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.needs_reset) |-> !rsp_data.status[7])
      else $error("reset flagged for an active station");

   a_fault_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.event_kind == psht_pkg::EV_LINE_FAULT)) |->
      ((rsp_data.event_b1 == psht_pkg::FAULT_B1) && (rsp_data.event_b2 == psht_pkg::FAULT_B2)))
      else $error("line fault with wrong event bytes");

endmodule
